>>> rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_POP_REAR   = 3'd2,
    OP_READ       = 3'd3,
    OP_INSERT     = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RA_ZERO,
    RA_REAR,
    RA_POS,
    RA_WALK_NEXT,
    RA_PTR_NEXT
  } rd_src_t;

  typedef enum logic [1:0] {
    WR_PUSH,
    WR_SHIFT,
    WR_PLACE
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    set_status;
    status_t status;
    logic    rd_en;
    rd_src_t rd_src;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    front_dec;
    logic    front_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    walk_clr;
    logic    walk_inc;
    logic    ptr_load;
    logic    ptr_dec;
    logic    take_elem;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              bad_pos;
    logic              less;
    logic              walk_last;
    logic              ptr_at;
    logic              out_free;
  } sts_t;

endpackage

>>> rtl/core/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bdq_pkg::sts_t sts,
  output bdq_pkg::cmd_t cmd
);
  import bdq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (sts.func)
          OP_PUSH_FRONT: state_next = S_DONE;
          OP_POP_FRONT,
          OP_POP_REAR:   state_next = sts.empty ? S_DONE : S_READ;
          OP_READ:       state_next = (sts.empty || sts.bad_pos) ? S_DONE : S_READ;
          OP_INSERT: begin
            if (sts.full) state_next = S_DONE;
            else if (sts.empty) state_next = S_PLACE;
            else state_next = S_SCAN;
          end
          default:       state_next = S_DONE;
        endcase
      end
      S_READ:  state_next = S_DONE;
      S_SCAN: begin
        if (!sts.less) state_next = S_SHIFT;
        else if (sts.walk_last) state_next = S_PLACE;
      end
      S_SHIFT: begin
        if (sts.ptr_at) state_next = S_PLACE;
      end
      S_PLACE: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        case (sts.func)
          OP_PUSH_FRONT: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = WR_PUSH;
              cmd.front_dec = 1'b1;
              cmd.cnt_inc   = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RA_ZERO;
            end
          end
          OP_POP_REAR: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RA_REAR;
            end
          end
          OP_READ: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else if (sts.bad_pos) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RA_POS;
            end
          end
          OP_INSERT: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.walk_clr = 1'b1;
              cmd.rd_en    = !sts.empty;
              cmd.rd_src   = RA_ZERO;
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        cmd.take_elem = 1'b1;
        if (sts.func == OP_POP_FRONT) begin
          cmd.front_inc = 1'b1;
          cmd.cnt_dec   = 1'b1;
        end else if (sts.func == OP_POP_REAR) begin
          cmd.cnt_dec = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.less) begin
          cmd.walk_inc = 1'b1;
          cmd.rd_en    = !sts.walk_last;
          cmd.rd_src   = RA_WALK_NEXT;
        end else begin
          cmd.ptr_load = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_src   = RA_REAR;
        end
      end
      S_SHIFT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.ptr_dec = 1'b1;
        cmd.rd_en   = !sts.ptr_at;
        cmd.rd_src  = RA_PTR_NEXT;
      end
      S_PLACE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_PLACE;
        cmd.cnt_inc = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/bdq_dp.sv
`timescale 1ns / 1ps

module bdq_dp #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bdq_pkg::cmd_t                    cmd,
  output bdq_pkg::sts_t                    sts,
  input  logic [bdq_pkg::FUNC_W-1:0]       func,
  input  logic signed [bdq_pkg::DATA_W-1:0] value,
  input  logic [$clog2(DEPTH+1)-1:0]       position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bdq_pkg::STAT_W-1:0]       status,
  output logic signed [bdq_pkg::DATA_W-1:0] element,
  output logic [$clog2(DEPTH+1)-1:0]       count
);
  import bdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;

  logic [FUNC_W-1:0]        func_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CW-1:0]            position_q;

  logic [CW-1:0] cnt;
  logic [AW-1:0] front;
  logic [CW-1:0] walk;
  logic [CW-1:0] ptr;

  status_t                  res_status;
  logic signed [DATA_W-1:0] res_elem;
  status_t                  out_status;
  logic signed [DATA_W-1:0] out_elem;
  logic [CW-1:0]            out_count;

  logic [AW-1:0]            front_dn;
  logic [AW-1:0]            front_up;
  logic [CW-1:0]            rd_idx;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] idx);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(idx);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign front_dn = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_up = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);

  always_comb begin
    case (cmd.rd_src)
      RA_ZERO:      rd_idx = '0;
      RA_REAR:      rd_idx = cnt - CW'(1);
      RA_POS:       rd_idx = position_q - CW'(1);
      RA_WALK_NEXT: rd_idx = walk + CW'(1);
      RA_PTR_NEXT:  rd_idx = ptr - CW'(2);
      default:      rd_idx = '0;
    endcase
  end

  assign raddr = slot_of(front, rd_idx);

  always_comb begin
    case (cmd.wr_sel)
      WR_PUSH: begin
        waddr = front_dn;
        wdata = value_q;
      end
      WR_SHIFT: begin
        waddr = slot_of(front, ptr);
        wdata = rdata;
      end
      WR_PLACE: begin
        waddr = slot_of(front, walk);
        wdata = value_q;
      end
      default: begin
        waddr = front_dn;
        wdata = value_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q     <= func;
      value_q    <= value;
      position_q <= position;
    end
    if (cmd.walk_clr) walk <= '0;
    else if (cmd.walk_inc) walk <= walk + CW'(1);
    if (cmd.ptr_load) ptr <= cnt;
    else if (cmd.ptr_dec) ptr <= ptr - CW'(1);
    if (cmd.load) res_elem <= '0;
    else if (cmd.take_elem) res_elem <= rdata;
    if (cmd.load) res_status <= ST_OK;
    else if (cmd.set_status) res_status <= cmd.status;
    if (cmd.out_load) begin
      out_status <= res_status;
      out_elem   <= res_elem;
      out_count  <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      front     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) cnt <= cnt + CW'(1);
      else if (cmd.cnt_dec) cnt <= cnt - CW'(1);
      if (cmd.front_dec) front <= front_dn;
      else if (cmd.front_inc) front <= front_up;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.func      = func_q;
    sts.full      = (cnt == CW'(DEPTH));
    sts.empty     = (cnt == '0);
    sts.bad_pos   = (position_q == '0) || (position_q > cnt);
    sts.less      = (rdata < value_q);
    sts.walk_last = ((CW+1)'(walk) + (CW+1)'(1)) == (CW+1)'(cnt);
    sts.ptr_at    = (CW+1)'(ptr) == ((CW+1)'(walk) + (CW+1)'(1));
    sts.out_free  = !out_valid || out_ready;
  end

  assign status  = out_status;
  assign element = out_elem;
  assign count   = out_count;

endmodule

>>> rtl/core/bounded_deque_with_sorted_insert.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// request   in_valid / in_ready   func, value, position
// result    out_valid / out_ready status, element, count
//
// One request at a time; a new request is taken once the previous result sits
// in the output register, whether or not it has been transferred.
// Push, pop and read go from idle through decode, a read state (pops and reads only) and done.
// Ordered insert walks the store one entry a cycle while it scans and shifts.
// Reset empties the store at once; entry contents are not cleared.
// A stalled result holds the block in its final state until the register frees.

module bounded_deque_with_sorted_insert #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bdq_pkg::FUNC_W-1:0]        func,
  input  logic signed [bdq_pkg::DATA_W-1:0] value,
  input  logic [$clog2(DEPTH+1)-1:0]        position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bdq_pkg::STAT_W-1:0]        status,
  output logic signed [bdq_pkg::DATA_W-1:0] element,
  output logic [$clog2(DEPTH+1)-1:0]        count
);
  import bdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cmd_t cmd;
  sts_t sts;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .func      (func),
    .value     (value),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .element   (element),
    .count     (count)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in progress");

  a_elem_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (element == '0))
    else $error("element not zero on error status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == CW'(DEPTH)))
    else $error("full status with spare room");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (count == '0))
    else $error("empty status with stored elements");

endmodule
